// ===== hdl/lfsm_pkg.sv =====
package lfsm_pkg;

  // Query register file holds sixteen bytes (two 64-bit words).
  localparam int QUERY_BYTES = 16;
  localparam int QUERY_W     = 8 * QUERY_BYTES;

  // Release counts never exceed sixteen queued starts.
  localparam int REL_W = 5;

  // Widest start-ring address (ring is at most 32 entries).
  localparam int RING_AW_MAX = 5;

  // Command queue between front and back.
  localparam int CMD_DEPTH = 4;
  localparam int CMD_AW    = 2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_QUERY_LENGTH = 2'd0;
  localparam logic [1:0] CFG_QUERY_LOW    = 2'd1;
  localparam logic [1:0] CFG_QUERY_HIGH   = 2'd2;
  localparam logic [1:0] CFG_CASE_SENS    = 2'd3;

  // Character codes.
  localparam logic [7:0] CH_AT    = 8'h40;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5a;
  localparam logic [7:0] CASE_GAP = 8'h20;

  // One command per input byte that produces results.
  typedef struct packed {
    logic [15:0]      node;
    logic             ovf;
    logic [REL_W-1:0] rel_count;  // queued starts to release, oldest first
    logic             direct;     // one more match after the released ones
    logic [31:0]      start;      // start offset of the direct match
  } cmd_t;

  // Write port into the start ring.
  typedef struct packed {
    logic                   we;
    logic [RING_AW_MAX-1:0] addr;
    logic [31:0]            data;
  } ring_wr_t;

  function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic fold);
    logic [7:0] r;
    r = c;
    if (fold && (c inside {[CH_UP_A:CH_UP_Z]})) r = c + CASE_GAP;
    return r;
  endfunction

endpackage

// ===== hdl/lfsm_front.sv =====
module lfsm_front
  import lfsm_pkg::*;
#(
  parameter int MAX_QUERY  = 16,
  parameter int QUEUE_CAP  = 16,
  parameter int RING_DEPTH = 32,
  parameter int RING_AW    = 5
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         text_byte,
  input  logic [31:0]        source_offset,
  input  logic [15:0]        node_number,
  input  logic               node_first,
  input  logic               node_final,
  input  logic [4:0]         query_length,
  input  logic [QUERY_W-1:0] query_vec,
  input  logic               exact_cmp,
  input  logic [RING_AW:0]   rd_ptr,
  input  logic               cmd_full,
  output logic               cmd_push,
  output cmd_t               cmd_data,
  output ring_wr_t           ring_wr
);

  localparam int FILL_W = $clog2(MAX_QUERY + 1);
  localparam int PC_W   = $clog2(QUEUE_CAP + 1);
  localparam int PTR_W  = RING_AW + 1;

  localparam logic [1:0] CLASS_BLANKS  = 2'd0;
  localparam logic [1:0] CLASS_TEXT    = 2'd1;
  localparam logic [1:0] CLASS_COMMAND = 2'd2;

  logic [7:0]        window [MAX_QUERY];
  logic [FILL_W-1:0] fill;
  logic [1:0]        line_class;
  logic [PC_W-1:0]   pending_count;
  logic              overflow_seen;
  logic [PTR_W-1:0]  base;   // first uncommitted ring slot

  logic [7:0]        win_new [MAX_QUERY];
  logic [FILL_W-1:0] fill_new;
  logic [1:0]        class0, class1;
  logic [PC_W-1:0]   pc0, pc1, pc2;
  logic              ov0, ov2;
  logic              is_lf, is_blank, ends_line, to_text, to_cmd;
  logic              hit, len_ok, enq;
  logic [MAX_QUERY-1:0] pos_ok;
  logic [REL_W-1:0]  rel;
  logic              direct;
  logic [31:0]       start;
  logic [PTR_W-1:0]  wr_ptr, ring_used;
  logic              accept;

  function automatic logic [7:0] qbyte_at(input logic [QUERY_W-1:0] q,
                                          input logic [4:0] len, input int j);
    int idx;
    logic [7:0] r;
    idx = int'(len) - 1 - j;
    r = '0;
    if (idx >= 0 && idx < QUERY_BYTES) r = q[idx*8 +: 8];
    return r;
  endfunction

  assign ring_used = (base + PTR_W'(pending_count)) - rd_ptr;
  assign in_ready  = !cmd_full && (ring_used != PTR_W'(RING_DEPTH));
  assign accept    = in_valid && in_ready;

  always_comb begin
    class0    = node_first ? CLASS_BLANKS : line_class;
    pc0       = node_first ? '0 : pending_count;
    ov0       = node_first ? 1'b0 : overflow_seen;
    is_lf     = (text_byte == CH_LF);
    is_blank  = (text_byte inside {CH_SPACE, CH_TAB, CH_CR});
    ends_line = is_lf || node_final;

    // window after this byte, newest at index 0
    win_new[0] = text_byte;
    for (int k = 1; k < MAX_QUERY; k++) win_new[k] = window[k-1];
    if (node_first)                      fill_new = FILL_W'(1);
    else if (fill == FILL_W'(MAX_QUERY)) fill_new = fill;
    else                                 fill_new = fill + FILL_W'(1);

    // compare against the query laid out newest-last
    len_ok = (query_length != 5'd0) && ({2'b00, query_length} <= 7'(MAX_QUERY)) &&
             (7'(fill_new) >= {2'b00, query_length});
    for (int j = 0; j < MAX_QUERY; j++) begin
      pos_ok[j] = (7'(j) >= {2'b00, query_length}) ||
                  (fold_byte(win_new[j], !exact_cmp) ==
                   fold_byte(qbyte_at(query_vec, query_length, j), !exact_cmp));
    end
    hit   = !is_lf && len_ok && (&pos_ok);
    start = source_offset - {27'd0, query_length} + 32'd1;

    // classification
    to_text = !is_lf && (class0 == CLASS_BLANKS) && !is_blank && (text_byte != CH_AT);
    to_cmd  = !is_lf && (class0 == CLASS_BLANKS) && !is_blank && (text_byte == CH_AT);
    class1  = to_text ? CLASS_TEXT : (to_cmd ? CLASS_COMMAND : class0);
    pc1     = (to_text || to_cmd) ? '0 : pc0;

    enq = hit && (class1 == CLASS_BLANKS) && (pc1 != PC_W'(QUEUE_CAP));
    ov2 = ov0 || (hit && (class1 == CLASS_BLANKS) && (pc1 == PC_W'(QUEUE_CAP)));
    pc2 = enq ? pc1 + PC_W'(1) : pc1;

    direct = hit && (class1 == CLASS_TEXT);
    rel    = '0;
    if (is_lf) begin
      if (class0 == CLASS_BLANKS) rel = REL_W'(pc0);
    end else if (to_text) begin
      rel = REL_W'(pc0);
    end else if (node_final && class1 == CLASS_BLANKS) begin
      rel = REL_W'(pc2);
    end

    wr_ptr = base + PTR_W'(pc1);
  end

  assign cmd_push           = accept && ((rel != '0) || direct);
  assign cmd_data.node      = node_number;
  assign cmd_data.ovf       = is_lf ? ov0 : ov2;
  assign cmd_data.rel_count = rel;
  assign cmd_data.direct    = direct;
  assign cmd_data.start     = start;

  assign ring_wr.we   = accept && enq;
  assign ring_wr.addr = RING_AW_MAX'(wr_ptr[RING_AW-1:0]);
  assign ring_wr.data = start;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill          <= '0;
      line_class    <= CLASS_BLANKS;
      pending_count <= '0;
      overflow_seen <= 1'b0;
      base          <= '0;
    end else if (accept) begin
      base <= base + PTR_W'(rel);
      if (ends_line) begin
        fill          <= '0;
        line_class    <= CLASS_BLANKS;
        pending_count <= '0;
        overflow_seen <= 1'b0;
      end else begin
        fill          <= fill_new;
        line_class    <= class1;
        pending_count <= pc2;
        overflow_seen <= ov2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !is_lf) begin
      for (int k = 0; k < MAX_QUERY; k++) window[k] <= win_new[k];
    end
  end

`ifndef SYNTHESIS
  a_pending_cap : assert property (@(posedge clk) disable iff (rst)
    pending_count <= PC_W'(QUEUE_CAP))
    else $error("pending count above queue capacity");
  a_ring_bound : assert property (@(posedge clk) disable iff (rst)
    ring_used <= PTR_W'(RING_DEPTH))
    else $error("start ring overrun");
`endif

endmodule

// ===== hdl/lfsm_cmd_fifo.sv =====
module lfsm_cmd_fifo
  import lfsm_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  output cmd_t head,
  output logic head_valid,
  input  logic pop
);

  cmd_t            mem [CMD_DEPTH];
  logic [CMD_AW-1:0] wptr, rptr;
  logic [CMD_AW:0]   count;

  assign full       = (count == (CMD_AW+1)'(CMD_DEPTH));
  assign head_valid = (count != '0);
  assign head       = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + CMD_AW'(1);
      if (pop)  rptr <= rptr + CMD_AW'(1);
      case ({push, pop})
        2'b10:   count <= count + (CMD_AW+1)'(1);
        2'b01:   count <= count - (CMD_AW+1)'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= push_data;
  end

endmodule

// ===== hdl/lfsm_back.sv =====
module lfsm_back
  import lfsm_pkg::*;
#(
  parameter int RING_DEPTH = 32,
  parameter int RING_AW    = 5
) (
  input  logic             clk,
  input  logic             rst,
  input  ring_wr_t         ring_wr,
  output logic [RING_AW:0] rd_ptr,
  input  cmd_t             head,
  input  logic             head_valid,
  output logic             pop,
  input  logic [4:0]       query_length,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [15:0]      match_node,
  output logic [31:0]      match_start,
  output logic [4:0]       match_length,
  output logic             pending_overflow,
  output logic             last_of_run
);

  logic [31:0]      ring [RING_DEPTH];
  logic [REL_W-1:0] rel_done;
  logic             load, from_ring, emit_last;

  assign load      = head_valid && (!out_valid || out_ready);
  assign from_ring = (rel_done < head.rel_count);
  assign emit_last = from_ring ?
                     ((rel_done + REL_W'(1) == head.rel_count) && !head.direct) : 1'b1;
  assign pop       = load && emit_last;

  always_ff @(posedge clk) begin
    if (ring_wr.we) ring[ring_wr.addr[RING_AW-1:0]] <= ring_wr.data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      rel_done  <= '0;
      rd_ptr    <= '0;
    end else if (load) begin
      out_valid <= 1'b1;
      rel_done  <= emit_last ? '0 : rel_done + REL_W'(1);
      if (from_ring) rd_ptr <= rd_ptr + (RING_AW+1)'(1);
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      match_node       <= head.node;
      match_start      <= from_ring ? ring[rd_ptr[RING_AW-1:0]] : head.start;
      match_length     <= query_length;
      pending_overflow <= head.ovf;
      last_of_run      <= emit_last;
    end
  end

`ifndef SYNTHESIS
  a_rel_in_range : assert property (@(posedge clk) disable iff (rst)
    head_valid |-> (rel_done < head.rel_count ||
                    (rel_done == head.rel_count && head.direct)))
    else $error("release counter past command");
  a_rel_idle : assert property (@(posedge clk) disable iff (rst)
    !head_valid |-> rel_done == '0)
    else $error("release counter busy with no command");
`endif

endmodule

// ===== hdl/line_filtered_substring_matcher_unit.sv =====
// Channel  Dir  Beat contents (low bit first)                     Handshake
// cfg      in   cfg_index: register, cfg_data: 64-bit value        cfg_valid/cfg_ready
// s_axis   in   tdata: text_byte, source_offset, node_number        tvalid/tready
//               tuser: node_first, tlast: node_final
// m_axis   out  tdata: match_node, match_start, match_length, pad   tvalid/tready
//               tuser: pending_overflow, tlast: last_of_run
//
// The front takes one text byte per cycle unless s_axis stalls; a byte that
// yields matches occupies the back for one result beat per match (released
// starts plus the match ending at this byte), so a line that releases N held
// matches costs N output beats. Each result's command is registered in the
// command queue, then the result in the back's output register, before tvalid rises.
// Reset is synchronous; there is no clearing pass.
// s_axis stalls when the 4-entry command queue or the start ring is full;
// m_axis back-pressure holds the back, so the queue and start ring fill. cfg_ready is always high.
module line_filtered_substring_matcher_unit
  import lfsm_pkg::*;
#(
  parameter int MAX_QUERY     = 16,
  parameter int PENDING_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,

  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,   // text_byte[7:0], source_offset[39:8], node_number[55:40]
  input  logic        s_axis_tuser,   // node_first
  input  logic        s_axis_tlast,   // node_final

  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // match_node[15:0], match_start[47:16],
                                      // match_length[52:48], zero[55:53]
  output logic        m_axis_tuser,   // pending_overflow
  output logic        m_axis_tlast    // last_of_run
);

  // held matches per line, capped at sixteen
  localparam int QUEUE_CAP  = (PENDING_DEPTH < 16) ? PENDING_DEPTH : 16;
  // start ring: room for one line being filled and one being drained
  localparam int RING_DEPTH = 2 ** $clog2(2 * QUEUE_CAP);
  localparam int RING_AW    = $clog2(RING_DEPTH);

  logic [4:0]  query_length;
  logic [63:0] query_bytes_low;
  logic [63:0] query_bytes_high;
  logic        exact_cmp;

  cmd_t             cmd_in, cmd_head;
  logic             cmd_push, cmd_full, cmd_valid, cmd_pop;
  ring_wr_t         ring_wr;
  logic [RING_AW:0] rd_ptr;

  logic [15:0] match_node;
  logic [31:0] match_start;
  logic [4:0]  match_length;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      query_length     <= '0;
      query_bytes_low  <= '0;
      query_bytes_high <= '0;
      exact_cmp        <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_QUERY_LENGTH: query_length     <= cfg_data[4:0];
        CFG_QUERY_LOW:    query_bytes_low  <= cfg_data;
        CFG_QUERY_HIGH:   query_bytes_high <= cfg_data;
        CFG_CASE_SENS:    exact_cmp        <= cfg_data[0];
        default:          ;
      endcase
    end
  end

  // front: window, line class, held-match bookkeeping
  lfsm_front #(
    .MAX_QUERY (MAX_QUERY),
    .QUEUE_CAP (QUEUE_CAP),
    .RING_DEPTH(RING_DEPTH),
    .RING_AW   (RING_AW)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s_axis_tvalid),
    .in_ready      (s_axis_tready),
    .text_byte     (s_axis_tdata[7:0]),
    .source_offset (s_axis_tdata[39:8]),
    .node_number   (s_axis_tdata[55:40]),
    .node_first    (s_axis_tuser),
    .node_final    (s_axis_tlast),
    .query_length  (query_length),
    .query_vec     ({query_bytes_high, query_bytes_low}),
    .exact_cmp     (exact_cmp),
    .rd_ptr        (rd_ptr),
    .cmd_full      (cmd_full),
    .cmd_push      (cmd_push),
    .cmd_data      (cmd_in),
    .ring_wr       (ring_wr)
  );

  lfsm_cmd_fifo u_cmd_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (cmd_push),
    .push_data (cmd_in),
    .full      (cmd_full),
    .head      (cmd_head),
    .head_valid(cmd_valid),
    .pop       (cmd_pop)
  );

  // back: expands each command into result beats
  lfsm_back #(
    .RING_DEPTH(RING_DEPTH),
    .RING_AW   (RING_AW)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .ring_wr         (ring_wr),
    .rd_ptr          (rd_ptr),
    .head            (cmd_head),
    .head_valid      (cmd_valid),
    .pop             (cmd_pop),
    .query_length    (query_length),
    .out_valid       (m_axis_tvalid),
    .out_ready       (m_axis_tready),
    .match_node      (match_node),
    .match_start     (match_start),
    .match_length    (match_length),
    .pending_overflow(m_axis_tuser),
    .last_of_run     (m_axis_tlast)
  );

  assign m_axis_tdata = {3'b000, match_length, match_start, match_node};

endmodule
